[sv/fermion_state_word_analyzer_assert.svh]
// Assertion macros shared by the fermion state word analyzer RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef FERMION_STATE_WORD_ANALYZER_ASSERT_SVH
`define FERMION_STATE_WORD_ANALYZER_ASSERT_SVH

// Property checked on every rising edge, off while reset is asserted.
`define FSWA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define FSWA_ASSERT_NEXT(lbl, clk, rstn, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (nxt)) else $error(msg);

`endif

[sv/fswa_pkg.sv]
// Package for the fermion state word analyzer: constants, register codes
// and the per-lane result record. No dependencies.
package fswa_pkg;

  // Word geometry
  localparam int WORD_W            = 32;
  localparam int WORD_SITES        = 16;
  localparam int LANE_SITES        = 4;
  localparam int LANE_BITS         = 2 * LANE_SITES;
  localparam int DEFAULT_MAX_SITES = 16;

  // Field widths
  localparam int COUNT_W    = 5;
  localparam int SZ_W       = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [COUNT_W-1:0] SITE_COUNT_RESET = 5'd16;

  // Site codes
  localparam logic [1:0] DOWN_CODE = 2'b10;
  localparam logic [1:0] UP_CODE   = 2'b11;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SITE_COUNT      = 2'd0,
    REG_FIXED_NUMBERS   = 2'd1,
    REG_FIXED_TWICE_SZ  = 2'd2,
    REG_FIXED_PARTICLES = 2'd3
  } cfg_reg_e;

  // What one lane reports about its group of sites
  typedef struct packed {
    logic [LANE_SITES-1:0] occ;      // occupied (bit 1 set) and active
    logic [LANE_SITES-1:0] par;      // occupancy parity from lane top down to site, inclusive
    logic                  grp_par;  // parity of all occupied sites in lane
    logic [2:0]            cnt;      // nonzero sites, 0..4
    logic signed [3:0]     sz;       // ups minus downs, -4..4
  } lane_res_t;

endpackage

[sv/fswa_lane.sv]
// One analysis lane: classifies a group of four sites and registers the result.
// Depends on fswa_pkg.
module fswa_lane (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [fswa_pkg::LANE_BITS-1:0]       word_i,
  input  logic [fswa_pkg::LANE_SITES-1:0]      act_i,
  output fswa_pkg::lane_res_t                  res_o
);
  import fswa_pkg::*;

  lane_res_t res_d, res_q;

  // Per-site classification and local suffix parity
  always_comb begin
    logic [1:0]        code;
    logic              p;
    logic [2:0]        ups;
    logic [2:0]        downs;
    res_d   = '0;
    p       = 1'b0;
    ups     = '0;
    downs   = '0;
    for (int k = LANE_SITES - 1; k >= 0; k--) begin
      code = word_i[2*k +: 2];
      res_d.occ[k] = act_i[k] & code[1];
      p            = p ^ res_d.occ[k];
      res_d.par[k] = p;
      if (act_i[k] && (code != 2'b00)) res_d.cnt = res_d.cnt + 3'd1;
      if (act_i[k] && (code == UP_CODE)) ups = ups + 3'd1;
      if (act_i[k] && (code == DOWN_CODE)) downs = downs + 3'd1;
    end
    res_d.grp_par = p;
    res_d.sz      = signed'({1'b0, ups}) - signed'({1'b0, downs});
  end

  // Lane result register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[sv/fswa_merge.sv]
// Merge stage: chains lane parities into the sign mask, sums counts and Sz,
// applies fixed mode, and registers the result. Depends on fswa_pkg.
module fswa_merge #(
  parameter int NUM_LANES = 4
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  fswa_pkg::lane_res_t [NUM_LANES-1:0]     lanes_i,
  input  logic                                    fixed_numbers_i,
  input  logic signed [fswa_pkg::SZ_W-1:0]        fixed_twice_sz_i,
  input  logic [fswa_pkg::COUNT_W-1:0]            fixed_particles_i,
  output logic                                    done_o,
  output logic [fswa_pkg::WORD_W-1:0]             sign_mask_o,
  output logic [fswa_pkg::COUNT_W-1:0]            particle_count_o,
  output logic signed [fswa_pkg::SZ_W-1:0]        twice_sz_o
);
  import fswa_pkg::*;

  logic                     done_q;
  logic [WORD_W-1:0]        mask_d, mask_q;
  logic [COUNT_W-1:0]       cnt_d, cnt_q;
  logic signed [SZ_W-1:0]   sz_d, sz_q;

  // Parity carry from the top lane down, then per-site mask bits
  always_comb begin
    logic                   c;
    logic                   even;
    logic [COUNT_W-1:0]     cnt_sum;
    logic signed [SZ_W-1:0] sz_sum;
    mask_d  = '0;
    c       = 1'b0;
    cnt_sum = '0;
    sz_sum  = '0;
    for (int l = NUM_LANES - 1; l >= 0; l--) begin
      for (int k = 0; k < LANE_SITES; k++) begin
        even = ~(lanes_i[l].par[k] ^ c);
        mask_d[2*(l*LANE_SITES+k) +: 2] = {2{lanes_i[l].occ[k] & even}};
      end
      c       = c ^ lanes_i[l].grp_par;
      cnt_sum = cnt_sum + {2'b00, lanes_i[l].cnt};
      sz_sum  = sz_sum + {{(SZ_W-4){lanes_i[l].sz[3]}}, lanes_i[l].sz};
    end
    cnt_d = fixed_numbers_i ? fixed_particles_i : cnt_sum;
    sz_d  = fixed_numbers_i ? fixed_twice_sz_i : sz_sum;
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      mask_q <= mask_d;
      cnt_q  <= cnt_d;
      sz_q   <= sz_d;
    end
  end

  assign done_o           = done_q;
  assign sign_mask_o      = mask_q;
  assign particle_count_o = cnt_q;
  assign twice_sz_o       = sz_q;

endmodule

[sv/fermion_state_word_analyzer.sv]
// Fermion state word analyzer: start reaches done_o through the lane and merge registers; one word
// accepted every cycle; busy is never raised and done_o is a one-cycle strobe.
// First, lanes of four sites classify the word in parallel and register the result;
// then the merge stage chains lane parities, sums counts and Sz, and registers.
// Reset (async, active low) clears the strobes and sets site_count to 16,
// fixed mode off, fixed values 0. Depends on fswa_pkg, fswa_lane, fswa_merge.
`include "fermion_state_word_analyzer_assert.svh"

module fermion_state_word_analyzer #(
  parameter int MAX_SITES = fswa_pkg::DEFAULT_MAX_SITES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [fswa_pkg::WORD_W-1:0]          state_word_i,
  output logic                                 done_o,
  output logic [fswa_pkg::WORD_W-1:0]          sign_mask_o,
  output logic [fswa_pkg::COUNT_W-1:0]         particle_count_o,
  output logic signed [fswa_pkg::SZ_W-1:0]     twice_sz_o,
  input  logic                                 cfg_we_i,
  input  logic [fswa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fswa_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import fswa_pkg::*;

  localparam int NUM_SITES = (MAX_SITES < WORD_SITES) ? MAX_SITES : WORD_SITES;
  localparam int NUM_LANES = (NUM_SITES + LANE_SITES - 1) / LANE_SITES;
  localparam int NUM_SLOTS = NUM_LANES * LANE_SITES;

  logic                       accept;
  logic                       s1_valid_q;
  logic [COUNT_W-1:0]         site_count_q;
  logic                       fixed_numbers_q;
  logic signed [SZ_W-1:0]     fixed_twice_sz_q;
  logic [COUNT_W-1:0]         fixed_particles_q;
  logic [NUM_SLOTS-1:0]       act;
  lane_res_t [NUM_LANES-1:0]  lane_res;

  // Fully pipelined: never stalls the sender
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_count_q      <= SITE_COUNT_RESET;
      fixed_numbers_q   <= 1'b0;
      fixed_twice_sz_q  <= '0;
      fixed_particles_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SITE_COUNT:      site_count_q      <= cfg_data_i[COUNT_W-1:0];
        REG_FIXED_NUMBERS:   fixed_numbers_q   <= cfg_data_i[0];
        REG_FIXED_TWICE_SZ:  fixed_twice_sz_q  <= cfg_data_i[SZ_W-1:0];
        REG_FIXED_PARTICLES: fixed_particles_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Active site map: below site_count and within the built site range
  always_comb begin
    act = '0;
    for (int j = 0; j < NUM_SITES; j++) begin
      act[j] = (COUNT_W'(j) < site_count_q);
    end
  end

  // Lane stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  // Parallel lanes
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    fswa_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (accept),
      .word_i (state_word_i[l*LANE_BITS +: LANE_BITS]),
      .act_i  (act[l*LANE_SITES +: LANE_SITES]),
      .res_o  (lane_res[l])
    );
  end

  // Merge and output register
  fswa_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (s1_valid_q),
    .lanes_i           (lane_res),
    .fixed_numbers_i   (fixed_numbers_q),
    .fixed_twice_sz_i  (fixed_twice_sz_q),
    .fixed_particles_i (fixed_particles_q),
    .done_o            (done_o),
    .sign_mask_o       (sign_mask_o),
    .particle_count_o  (particle_count_o),
    .twice_sz_o        (twice_sz_o)
  );

  // Checks
  `FSWA_ASSERT_NEXT(a_accept_to_lanes, clk_i, rst_ni, accept, s1_valid_q, "lane stage missed a transfer")
  `FSWA_ASSERT_NEXT(a_lanes_to_done, clk_i, rst_ni, s1_valid_q, done_o, "merge stage dropped a result")
  `FSWA_ASSERT_NEXT(a_no_spurious_done, clk_i, rst_ni, !s1_valid_q, !done_o, "result strobe without a transfer")
  `FSWA_ASSERT(a_mask_pairs, clk_i, rst_ni, !done_o || ((sign_mask_o & 32'h5555_5555) == ((sign_mask_o >> 1) & 32'h5555_5555)), "sign mask site bits disagree")
  `FSWA_ASSERT(a_mask_in_range, clk_i, rst_ni, !done_o || ((sign_mask_o >> {site_count_q, 1'b0}) == '0), "sign mask set above active sites")
  `FSWA_ASSERT(a_count_bound, clk_i, rst_ni, !done_o || fixed_numbers_q || (particle_count_o <= SITE_COUNT_RESET), "particle count above site range")

endmodule
